// ----- hdl/jst_pkg.sv -----
// ----------------------------------------------------------------------------
// jst_pkg
// shared types, widths and codes for the job slot table
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int TABLE_SIZE_DEF = 16;

    localparam int FUNC_W  = 3;
    localparam int PID_W   = 23;
    localparam int NUM_W   = 5;
    localparam int STATE_W = 2;
    localparam int SLOT_W  = 4;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND_PID = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND_NUM = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND_FG  = 3'd4;

    // run state codes
    localparam logic [STATE_W-1:0] RUN_FOREGROUND = 2'd2;

    typedef struct packed {
        logic [STATE_W-1:0] run_state;
        logic [NUM_W-1:0]   number;
        logic [PID_W-1:0]   pid;
    } entry_t;

    typedef struct packed {
        logic [STATE_W-1:0] slot_state;
        logic [NUM_W-1:0]   slot_number;
        logic [PID_W-1:0]   slot_pid;
        logic [SLOT_W-1:0]  slot;
        logic               found;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_DELIVER
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic publish;
    } jst_cmd_t;

    typedef struct packed {
        logic last_addr;
    } jst_status_t;

endpackage

// ----- hdl/jst_datapath.sv -----
// ----------------------------------------------------------------------------
// jst_datapath
// slot memory, scan pointer, match and maximum tracking, result registers
// ----------------------------------------------------------------------------
module jst_datapath #(
    parameter int TABLE_SIZE = jst_pkg::TABLE_SIZE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  jst_pkg::jst_cmd_t            cmd,
    output jst_pkg::jst_status_t         status,
    input  logic [jst_pkg::FUNC_W-1:0]   in_func,
    input  logic [jst_pkg::PID_W-1:0]    in_pid,
    input  logic [jst_pkg::NUM_W-1:0]    in_number,
    input  logic [jst_pkg::STATE_W-1:0]  in_state,
    output jst_pkg::result_t             out_result
);

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
    localparam logic [6:0]    SIZE_V   = 7'(TABLE_SIZE);

    // slot memory and per-slot written flags
    jst_pkg::entry_t mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg, valid_next;

    // request held during the scan
    logic [jst_pkg::FUNC_W-1:0]  op_reg;
    logic [jst_pkg::PID_W-1:0]   pid_reg;
    logic [jst_pkg::NUM_W-1:0]   num_reg;
    logic [jst_pkg::STATE_W-1:0] rs_reg;
    logic                        op_ok_reg;
    logic                        op_ok;

    // scan pointer and read pipeline
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   rd_idx_reg;
    logic            rd_valid_reg;
    logic            rd_vbit_reg;
    jst_pkg::entry_t rd_data_reg;
    jst_pkg::entry_t ent;
    logic            match;

    // scan results
    logic                      hit_found_reg, hit_found_next;
    logic [IW-1:0]             hit_idx_reg, hit_idx_next;
    jst_pkg::entry_t           hit_data_reg, hit_data_next;
    logic [jst_pkg::NUM_W-1:0] max_reg, max_next;
    logic [jst_pkg::NUM_W-1:0] next_num_reg, next_num_next;
    logic [jst_pkg::NUM_W-1:0] num_inc;

    // commit
    logic                wr_en;
    jst_pkg::entry_t     wr_data;
    logic [IW+3:0]       idx_ext;
    jst_pkg::result_t    res_reg, res_next;
    jst_pkg::result_t    out_reg;

    assign status.last_addr = (cnt_reg == LAST_IDX);
    assign out_result       = out_reg;

    always_comb begin
        case (in_func)
            jst_pkg::FUNC_ADD,
            jst_pkg::FUNC_DELETE,
            jst_pkg::FUNC_FIND_PID: op_ok = (in_pid != '0);
            jst_pkg::FUNC_FIND_NUM: op_ok = (in_number != '0);
            jst_pkg::FUNC_FIND_FG:  op_ok = 1'b1;
            default:                op_ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_func;
            pid_reg   <= in_pid;
            num_reg   <= in_number;
            rs_reg    <= in_state;
            op_ok_reg <= op_ok;
        end
    end

    // registered read port, slots never written read as free
    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_data_reg <= mem[cnt_reg];
            rd_vbit_reg <= valid_reg[cnt_reg];
            rd_idx_reg  <= cnt_reg;
        end
    end

    assign ent = rd_vbit_reg ? rd_data_reg : '0;

    always_comb begin
        case (op_reg)
            jst_pkg::FUNC_ADD:      match = (ent.pid == '0);
            jst_pkg::FUNC_DELETE,
            jst_pkg::FUNC_FIND_PID: match = (ent.pid == pid_reg);
            jst_pkg::FUNC_FIND_NUM: match = (ent.number == num_reg);
            jst_pkg::FUNC_FIND_FG:  match = (ent.run_state == jst_pkg::RUN_FOREGROUND);
            default:                match = 1'b0;
        endcase
        match = match && op_ok_reg;
    end

    always_comb begin
        cnt_next       = cnt_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_data_next  = hit_data_reg;
        max_next       = max_reg;
        if (cmd.load) begin
            cnt_next       = '0;
            hit_found_next = 1'b0;
            max_next       = '0;
        end else begin
            if (cmd.scan) begin
                cnt_next = cnt_reg + IW'(1);
            end
            if (rd_valid_reg) begin
                // first match is the target; every other slot counts for the maximum
                if (match && !hit_found_reg) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_data_next  = ent;
                end else if (ent.number > max_reg) begin
                    max_next = ent.number;
                end
            end
        end
    end

    assign num_inc = next_num_reg + jst_pkg::NUM_W'(1);
    assign idx_ext = {4'b0000, hit_idx_reg};

    always_comb begin
        wr_en         = 1'b0;
        wr_data       = '0;
        next_num_next = next_num_reg;
        res_next      = res_reg;
        valid_next    = valid_reg;
        if (cmd.commit) begin
            res_next = '0;
            if (hit_found_reg) begin
                res_next.found       = 1'b1;
                res_next.slot        = idx_ext[3:0];
                res_next.slot_pid    = hit_data_reg.pid;
                res_next.slot_number = hit_data_reg.number;
                res_next.slot_state  = hit_data_reg.run_state;
                case (op_reg)
                    jst_pkg::FUNC_ADD: begin
                        wr_en             = 1'b1;
                        wr_data.pid       = pid_reg;
                        wr_data.number    = next_num_reg;
                        wr_data.run_state = rs_reg;
                        res_next.slot_pid    = pid_reg;
                        res_next.slot_number = next_num_reg;
                        res_next.slot_state  = rs_reg;
                        next_num_next = ({2'b00, num_inc} > SIZE_V) ?
                                        jst_pkg::NUM_W'(1) : num_inc;
                    end
                    jst_pkg::FUNC_DELETE: begin
                        wr_en         = 1'b1;
                        next_num_next = max_reg + jst_pkg::NUM_W'(1);
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
                if (wr_en) begin
                    valid_next[hit_idx_reg] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[hit_idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            next_num_reg  <= jst_pkg::NUM_W'(1);
            hit_found_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            valid_reg     <= valid_next;
            next_num_reg  <= next_num_next;
            hit_found_reg <= hit_found_next;
            rd_valid_reg  <= cmd.scan;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg  <= hit_idx_next;
        hit_data_reg <= hit_data_next;
        max_reg      <= max_next;
        res_reg      <= res_next;
        if (cmd.publish) begin
            out_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_rd_follows_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(cmd.scan))
        else $error("read data valid without a scan read");

    a_load_clears_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !hit_found_reg && (max_reg == '0))
        else $error("scan results not cleared on new request");

    a_write_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> hit_found_reg && cmd.commit)
        else $error("slot write without a target slot");
`endif

endmodule

// ----- hdl/jst_ctrl.sv -----
// ----------------------------------------------------------------------------
// jst_ctrl
// request sequencer: accept, scan, drain, commit, deliver
// ----------------------------------------------------------------------------
module jst_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  jst_pkg::jst_status_t  status,
    output jst_pkg::jst_cmd_t     cmd
);

    jst_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            jst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = jst_pkg::ST_SCAN;
                end
            end
            jst_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.last_addr) begin
                    state_next = jst_pkg::ST_DRAIN;
                end
            end
            jst_pkg::ST_DRAIN: begin
                state_next = jst_pkg::ST_COMMIT;
            end
            jst_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = jst_pkg::ST_DELIVER;
            end
            jst_pkg::ST_DELIVER: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = jst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jst_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> out_free)
        else $error("result overwrites one not yet taken");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken during a scan");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == jst_pkg::ST_SCAN && status.last_addr) |=>
        (state_reg == jst_pkg::ST_DRAIN))
        else $error("scan did not stop at the last slot");
`endif

endmodule

// ----- hdl/job_slot_table.sv -----
// ----------------------------------------------------------------------------
// job_slot_table
// fixed table of job slots with add, delete and lookup requests
// ----------------------------------------------------------------------------
// Holds TABLE_SIZE slots of {pid, job number, run state}; a slot is free when
// its pid is zero, and all slots are free after reset. Each request on the
// s_ side is one of: add (lowest free slot, gets the rolling next job
// number), delete by pid (lowest matching slot, next number becomes the
// largest number still held plus one), find by pid, find by job number, find
// first foreground job. Exactly one result comes back on the m_ side per
// request. After a request is accepted the block reads the slot memory once
// per slot through its single registered read port, waits for the last read
// to return, commits, and loads the output register once the previous result
// has been taken. Requests are handled one at a time: the next request is
// taken as soon as the result sits in the output register, even if it has
// not been taken yet. A pid of zero, a job number of zero, a full table or
// an unknown request code give found low and all other result fields zero.
// ----------------------------------------------------------------------------
module job_slot_table #(
    parameter int TABLE_SIZE = jst_pkg::TABLE_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pid[22:0], number[27:23], run_state[29:28], zero[31:30]
    input  logic [2:0]  s_tuser,   // func[2:0]

    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // slot[3:0], slot_pid[26:4], slot_number[31:27],
                                   // slot_state[33:32], zero[39:34]
    output logic [0:0]  m_tuser    // found[0]
);

    jst_pkg::jst_cmd_t    cmd;
    jst_pkg::jst_status_t status;
    jst_pkg::result_t     result;

    // sequencer owns the handshakes and the output valid flag
    jst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // slot memory and scan logic, request fields unpacked from the stream
    jst_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_func    (s_tuser),
        .in_pid     (s_tdata[22:0]),
        .in_number  (s_tdata[27:23]),
        .in_state   (s_tdata[29:28]),
        .out_result (result)
    );

    // pack the result, found rides on tuser
    assign m_tuser = result.found;
    assign m_tdata = {6'b000000, result.slot_state, result.slot_number,
                      result.slot_pid, result.slot};

endmodule

// ----- dv/job_slot_table_test.sv -----
// ----------------------------------------------------------------------------
// job_slot_table_test
// self-checking testbench for the job slot table
// ----------------------------------------------------------------------------
// Drives add, delete and lookup requests into the table and checks every
// result against a behavioral copy of the table kept here or the row's own
// written result. A short directed walk covers the reset state, the field
// extremes, rejected zero pid and zero number, duplicate pids and the unused
// request codes. The random part then mixes add-heavy, delete-heavy and
// balanced stretches, so the table fills up, empties out and wraps its job
// number. Random bursts and gaps on the sender side work against a receiver
// with its own stall patterns and now and then a long hold-off.
// ----------------------------------------------------------------------------
module job_slot_table_test;

    localparam int TABLE_SIZE   = jst_pkg::TABLE_SIZE_DEF;
    localparam int RANDOM_ITEMS = 1880;
    localparam int POOL_SIZE    = 24;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int REPORT_MAX   = 10;

    // request codes the block ignores
    localparam logic [jst_pkg::FUNC_W-1:0] FUNC_RESERVED_A = 3'd5;
    localparam logic [jst_pkg::FUNC_W-1:0] FUNC_RESERVED_B = 3'd6;
    localparam logic [jst_pkg::FUNC_W-1:0] FUNC_RESERVED_C = 3'd7;

    // run states besides foreground
    localparam logic [jst_pkg::STATE_W-1:0] RUN_UNDEFINED  = 2'd0;
    localparam logic [jst_pkg::STATE_W-1:0] RUN_BACKGROUND = 2'd1;
    localparam logic [jst_pkg::STATE_W-1:0] RUN_STOPPED    = 2'd3;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_PATTERN,
        SINK_RARE
    } sink_mode_t;

    typedef struct {
        logic [jst_pkg::FUNC_W-1:0]  func;
        logic [jst_pkg::PID_W-1:0]   pid;
        logic [jst_pkg::NUM_W-1:0]   number;
        logic [jst_pkg::STATE_W-1:0] run_state;
        bit                          typed;     // result written out in the row
        jst_pkg::result_t            want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // pid[22:0], number[27:23], run_state[29:28], zero[31:30]
    logic [2:0]  s_tuser;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // slot[3:0], slot_pid[26:4], slot_number[31:27],
                            // slot_state[33:32], zero[39:34]
    logic [0:0]  m_tuser;   // found[0]

    // shadow copy of the slot table
    logic [jst_pkg::PID_W-1:0]   job_pid   [TABLE_SIZE];
    logic [jst_pkg::NUM_W-1:0]   job_num   [TABLE_SIZE];
    logic [jst_pkg::STATE_W-1:0] job_state [TABLE_SIZE];
    logic [jst_pkg::NUM_W-1:0]   roll_number;

    jst_pkg::result_t          pending_results[$];
    stim_row_t                 directed_rows[$];
    logic [jst_pkg::PID_W-1:0] pid_pool[POOL_SIZE];
    int                        fail_count;
    int                        idle_cycles;
    int                        burst_left;

    job_slot_table #(
        .TABLE_SIZE(TABLE_SIZE)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("error: %s", msg);
        end
    endtask

    // applies one request to the shadow table and returns what the block owes
    function automatic jst_pkg::result_t predict_job_table(
            input logic [jst_pkg::FUNC_W-1:0] func,
            input logic [jst_pkg::PID_W-1:0] pid,
            input logic [jst_pkg::NUM_W-1:0] number,
            input logic [jst_pkg::STATE_W-1:0] run_state);
        jst_pkg::result_t          res;
        int                        hit;
        logic [jst_pkg::NUM_W-1:0] top;
        res = '0;
        hit = -1;
        top = '0;
        case (func)
            jst_pkg::FUNC_ADD: begin
                if (pid != '0) begin
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        if (hit < 0 && job_pid[i] == '0) hit = i;
                    end
                    if (hit >= 0) begin
                        job_pid[hit]   = pid;
                        job_state[hit] = run_state;
                        job_num[hit]   = roll_number;
                        // 5-bit increment, then wrap back to one past the table size
                        roll_number = roll_number + 1'b1;
                        if (roll_number > TABLE_SIZE) roll_number = 1;
                    end
                end
            end
            jst_pkg::FUNC_DELETE, jst_pkg::FUNC_FIND_PID: begin
                if (pid != '0) begin
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        if (hit < 0 && job_pid[i] == pid) hit = i;
                    end
                end
            end
            jst_pkg::FUNC_FIND_NUM: begin
                if (number != '0) begin
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        if (hit < 0 && job_num[i] == number) hit = i;
                    end
                end
            end
            jst_pkg::FUNC_FIND_FG: begin
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    if (hit < 0 && job_state[i] == jst_pkg::RUN_FOREGROUND) hit = i;
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            res.found       = 1'b1;
            res.slot        = jst_pkg::SLOT_W'(hit);
            res.slot_pid    = job_pid[hit];
            res.slot_number = job_num[hit];
            res.slot_state  = job_state[hit];
            // delete reports the slot as it was, then frees it
            if (func == jst_pkg::FUNC_DELETE) begin
                job_pid[hit]   = '0;
                job_num[hit]   = '0;
                job_state[hit] = RUN_UNDEFINED;
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    if (job_num[i] > top) top = job_num[i];
                end
                roll_number = top + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic stim_row_t mk_row(input logic [jst_pkg::FUNC_W-1:0] func,
                                         input logic [jst_pkg::PID_W-1:0] pid,
                                         input logic [jst_pkg::NUM_W-1:0] number,
                                         input logic [jst_pkg::STATE_W-1:0] run_state,
                                         input bit typed, input logic found,
                                         input logic [jst_pkg::SLOT_W-1:0] slot,
                                         input logic [jst_pkg::PID_W-1:0] slot_pid,
                                         input logic [jst_pkg::NUM_W-1:0] slot_number,
                                         input logic [jst_pkg::STATE_W-1:0] slot_state);
        stim_row_t row;
        row.func             = func;
        row.pid              = pid;
        row.number           = number;
        row.run_state        = run_state;
        row.typed            = typed;
        row.want.found       = found;
        row.want.slot        = slot;
        row.want.slot_pid    = slot_pid;
        row.want.slot_number = slot_number;
        row.want.slot_state  = slot_state;
        return row;
    endfunction

    // offers one request, honoring the burst and gap pattern, and records
    // the expected result once the block takes it
    task automatic offer_request(input logic [jst_pkg::FUNC_W-1:0] func,
                                 input logic [jst_pkg::PID_W-1:0] pid,
                                 input logic [jst_pkg::NUM_W-1:0] number,
                                 input logic [jst_pkg::STATE_W-1:0] run_state,
                                 input bit typed, input jst_pkg::result_t want);
        int               gap;
        jst_pkg::result_t predicted;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(10, 45);
                default: gap = $urandom_range(1, 6);
            endcase
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, run_state, number, pid};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_job_table(func, pid, number, run_state);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // sender pause until the block has answered everything
    task automatic wait_for_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // mostly pids that sit in the table or a small pool, so hits are common
    function automatic logic [jst_pkg::PID_W-1:0] pick_pid();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, TABLE_SIZE - 1);
        if (pick < 3) return '0;
        if (pick < 10) return jst_pkg::PID_W'($urandom);
        if (pick < 60 && job_pid[idx] != '0) return job_pid[idx];
        return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // request driver
    initial begin : request_source
        int                          mix;
        int                          pick;
        int                          add_w;
        int                          del_w;
        logic [jst_pkg::FUNC_W-1:0]  func;
        logic [jst_pkg::NUM_W-1:0]   number;
        logic [jst_pkg::STATE_W-1:0] run_state;

        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        fail_count = 0;
        burst_left = 0;
        mix        = 0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            job_pid[i]   = '0;
            job_num[i]   = '0;
            job_state[i] = RUN_UNDEFINED;
        end
        roll_number = 1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pid_pool[i] = jst_pkg::PID_W'($urandom);
            if (pid_pool[i] == '0) pid_pool[i] = 1;
        end
        pid_pool[0] = 23'h7FFFFF;
        pid_pool[1] = 23'h000001;

        // directed walk: reset state, extremes, rejects, duplicates, spare codes
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_FG, '0, '0, RUN_UNDEFINED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_PID, 23'h7FFFFF, '0, RUN_UNDEFINED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_NUM, '0, '0, RUN_UNDEFINED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_ADD, '0, 5'd31, jst_pkg::RUN_FOREGROUND,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_ADD, 23'h7FFFFF, 5'd31, RUN_STOPPED,
                                       1, 1, 0, 23'h7FFFFF, 1, RUN_STOPPED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_ADD, 23'h000001, '0,
                                       jst_pkg::RUN_FOREGROUND,
                                       1, 1, 1, 23'h000001, 2, jst_pkg::RUN_FOREGROUND));
        // same pid again lands in the next free slot
        directed_rows.push_back(mk_row(jst_pkg::FUNC_ADD, 23'h000001, '0, RUN_BACKGROUND,
                                       1, 1, 2, 23'h000001, 3, RUN_BACKGROUND));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_ADD, 23'h400000, '0, RUN_UNDEFINED,
                                       1, 1, 3, 23'h400000, 4, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_FG, '0, '0, RUN_UNDEFINED,
                                       1, 1, 1, 23'h000001, 2, jst_pkg::RUN_FOREGROUND));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_PID, 23'h000001, '0, RUN_UNDEFINED,
                                       1, 1, 1, 23'h000001, 2, jst_pkg::RUN_FOREGROUND));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_NUM, '0, 5'd3, RUN_UNDEFINED,
                                       1, 1, 2, 23'h000001, 3, RUN_BACKGROUND));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_NUM, '0, 5'd31, RUN_UNDEFINED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_DELETE, '0, '0, RUN_UNDEFINED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(FUNC_RESERVED_A, 23'h000001, 5'd2,
                                       jst_pkg::RUN_FOREGROUND,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(FUNC_RESERVED_B, 23'h400000, 5'd1, RUN_BACKGROUND,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(FUNC_RESERVED_C, 23'h7FFFFF, 5'd31, RUN_STOPPED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_DELETE, 23'h000001, '0, RUN_UNDEFINED,
                                       1, 1, 1, 23'h000001, 2, jst_pkg::RUN_FOREGROUND));
        // from here on the shadow table supplies the answer unless the row writes it out
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_PID, 23'h000001, '0, RUN_UNDEFINED,
                                       0, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_DELETE, 23'h400000, '0, RUN_UNDEFINED,
                                       0, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_ADD, 23'h000002, '0,
                                       jst_pkg::RUN_FOREGROUND,
                                       0, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_FG, '0, '0, RUN_UNDEFINED,
                                       0, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_DELETE, 23'h000005, '0, RUN_UNDEFINED,
                                       1, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_DELETE, 23'h7FFFFF, '0, RUN_UNDEFINED,
                                       0, 0, 0, '0, 0, RUN_UNDEFINED));
        directed_rows.push_back(mk_row(jst_pkg::FUNC_FIND_NUM, '0, 5'd1, RUN_UNDEFINED,
                                       0, 0, 0, '0, 0, RUN_UNDEFINED));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].func, directed_rows[i].pid,
                          directed_rows[i].number, directed_rows[i].run_state,
                          directed_rows[i].typed, directed_rows[i].want);
        end
        wait_for_results();

        // random part: stretches biased toward filling or emptying the table, or balanced
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) mix = $urandom_range(0, 2);
            if (n % 400 == 399) wait_for_results();
            add_w = (mix == 0) ? 55 : (mix == 1) ? 15 : 30;
            del_w = (mix == 1) ? 45 : 15;
            pick  = $urandom_range(0, 99);
            if (pick < add_w) begin
                func = jst_pkg::FUNC_ADD;
            end else if (pick < add_w + del_w) begin
                func = jst_pkg::FUNC_DELETE;
            end else if (pick < 97) begin
                case ($urandom_range(0, 2))
                    0:       func = jst_pkg::FUNC_FIND_PID;
                    1:       func = jst_pkg::FUNC_FIND_NUM;
                    default: func = jst_pkg::FUNC_FIND_FG;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       func = FUNC_RESERVED_A;
                    1:       func = FUNC_RESERVED_B;
                    default: func = FUNC_RESERVED_C;
                endcase
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) number = '0;
            else if (pick == 1) number = jst_pkg::NUM_W'($urandom);
            else number = jst_pkg::NUM_W'($urandom_range(1, TABLE_SIZE + 2));
            run_state = jst_pkg::STATE_W'($urandom_range(0, 3));
            offer_request(func, pick_pid(), number, run_state, 0, '0);
        end

        wait_for_results();
        repeat (TABLE_SIZE + 8) @(posedge aclk);
        if (pending_results.size() != 0) report_failure("results never delivered");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result receiver: switches between random stall modes, with a long
    // hold-off now and then so the block backs up into its input
    initial begin : result_sink
        int         cyc;
        sink_mode_t mode;
        m_tready <= 1'b0;
        cyc  = 0;
        mode = SINK_OPEN;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 256 == 0) mode = sink_mode_t'($urandom_range(0, 3));
            if (cyc % 6000 == 3000) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                cyc += LONG_HOLD;
            end
            case (mode)
                SINK_OPEN:    m_tready <= 1'b1;
                SINK_COIN:    m_tready <= 1'($urandom_range(0, 1));
                SINK_PATTERN: m_tready <= (cyc % 7) < 4;
                default:      m_tready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        jst_pkg::result_t got;
        jst_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.found       = m_tuser[0];
            got.slot        = m_tdata[3:0];
            got.slot_pid    = m_tdata[26:4];
            got.slot_number = m_tdata[31:27];
            got.slot_state  = m_tdata[33:32];
            if (pending_results.size() == 0) begin
                report_failure($sformatf("result with no request behind it: found=%0b slot=%0d",
                                         got.found, got.slot));
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.slot !== want.slot ||
                    got.slot_pid !== want.slot_pid || got.slot_number !== want.slot_number ||
                    got.slot_state !== want.slot_state) begin
                    report_failure($sformatf(
                        "exp found=%0b slot=%0d pid=%06h num=%0d st=%0d, got %0b %0d %06h %0d %0d",
                        want.found, want.slot, want.slot_pid, want.slot_number,
                        want.slot_state, got.found, got.slot, got.slot_pid,
                        got.slot_number, got.slot_state));
                end
            end
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- job_slot_table.f -----
hdl/jst_pkg.sv
hdl/jst_datapath.sv
hdl/jst_ctrl.sv
hdl/job_slot_table.sv
dv/job_slot_table_test.sv
